// ===== rtl/mml_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mml_pkg: shared types and constants of the maximal-munch lexer
// Operation codes, controller states and the command/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package mml_pkg;

    // field widths fixed by the item format
    localparam int STATE_W = 6;
    localparam int CODE_W  = 16;
    localparam int OFF_W   = 32;
    localparam int SYM_W   = 8;

    // default sizes
    localparam int DEF_NUM_STATES = 64;
    localparam int DEF_LOOKAHEAD  = 32;

    // operation codes on s_tuser
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FINAL = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_EOI   = 2'd3;

    // result kinds
    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // register index (paddr[2])
    localparam logic REG_START_STATE = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_RANGE,
        ST_BUF,
        ST_TRANS,
        ST_FINAL,
        ST_BEST,
        ST_RESOLVE,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic clr;      // clearing sweep step
        logic acc;      // input word accepted
        logic load;     // write one transition of a range
        logic step;     // take the transition just read
        logic upd;      // record accept from final table
        logic resolve;  // cut a token
        logic finish;   // close the item
    } mml_cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic       range_done;
        logic [1:0] op;
        logic       range_req;
        logic       scan_more;
        logic       full;
        logic       nonempty;
        logic       dead;
        logic       can_push;
        logic       pend_valid;
    } mml_status_t;

endpackage

// ===== rtl/dfa_maximal_munch_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfa_maximal_munch_lexer: maximal-munch tokeniser over a loadable DFA
// Usage:
//   s_ channel words carry table loads (op 0 range, op 1 final mark), text
//   bytes (op 2) and end of input (op 3), op on s_tuser.
//   m_ channel words carry tokens or one-byte errors; m_tlast marks the last
//   result caused by one input word. The APB port holds start_state at 0x0.
//   After reset a clearing sweep over all NUM_STATES*256 table addresses
//   (16384 by default) empties the transition and final tables; s_tready
//   stays low meanwhile. Loads: op 1 writes the final table as the word is
//   accepted; op 0 then writes one transition per symbol, first to last.
//   Text: each word is accepted, scanned and closed; each byte the scan
//   takes passes check, buffer, transition and final-table reads and an
//   accept update. A dead transition shows at the final-table read; the
//   cut follows and the bytes left are rescanned. Results go through a
//   pending slot and an output register; while m_tready is low, a cut or
//   close with a result to pass on stalls once both hold a word.
// ----------------------------------------------------------------------------
module dfa_maximal_munch_lexer
    import mml_pkg::*;
#(
    parameter int NUM_STATES = DEF_NUM_STATES,
    parameter int LOOKAHEAD  = DEF_LOOKAHEAD
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    // state_index, symbol_first, symbol_last, next_state, entry_valid,
    // token_code, data_byte, zero pad
    input  logic [55:0] s_tdata,
    // op
    input  logic [1:0]  s_tuser,
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_code_out, start_offset, end_offset
    output logic [79:0] m_tdata,
    // kind, forced_cut
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mml_cmd_t           cmd;
    mml_status_t        st;
    logic               cfg_we;
    logic [STATE_W-1:0] start_state;
    logic               m_kind, m_forced;

    // register write decode
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_START_STATE);
    assign prdata = (paddr[2] == REG_START_STATE) ? 32'(start_state) : '0;

    mml_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mml_datapath #(
        .NUM_STATES (NUM_STATES),
        .LOOKAHEAD  (LOOKAHEAD)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st          (st),
        .in_op       (s_tuser),
        .in_sidx     (s_tdata[5:0]),
        .in_lo       (s_tdata[13:6]),
        .in_hi       (s_tdata[21:14]),
        .in_to       (s_tdata[27:22]),
        .in_ev       (s_tdata[28]),
        .in_code     (s_tdata[44:29]),
        .in_byte     (s_tdata[52:45]),
        .cfg_we      (cfg_we),
        .cfg_start   (pwdata[STATE_W-1:0]),
        .start_state (start_state),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_kind      (m_kind),
        .m_forced    (m_forced),
        .m_last      (m_tlast),
        .m_code      (m_tdata[15:0]),
        .m_start     (m_tdata[47:16]),
        .m_end       (m_tdata[79:48])
    );

    assign m_tuser = {m_forced, m_kind};

`ifndef SYNTHESIS
    // no result held back while waiting for a new word
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !st.pend_valid)
        else $error("pending result while idle");

    // a cut always has buffered bytes behind it
    a_cut_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.resolve |-> st.nonempty)
        else $error("token cut on empty buffer");

    // closing a word returns to idle
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_tready)
        else $error("not idle after closing word");
`endif

endmodule

// ===== rtl/mml_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mml_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mml_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mml_ctrl: lexer sequencer
// Runs the clearing sweep, range loads, the per-byte scan loop, token cuts
// and the closing of each input word.
// ----------------------------------------------------------------------------
module mml_ctrl
    import mml_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  mml_status_t st,
    output mml_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (st.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (st.op == OP_LOAD || st.op == OP_FINAL) begin
                    state_next = (st.op == OP_LOAD && st.range_req) ? ST_RANGE : ST_IDLE;
                end else if (st.scan_more) begin
                    state_next = ST_BUF;
                end else if (st.op == OP_DATA && st.full) begin
                    state_next = ST_RESOLVE;
                end else if (st.op == OP_EOI && st.nonempty) begin
                    state_next = ST_RESOLVE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_RANGE: begin
                if (st.range_done) state_next = ST_IDLE;
            end
            ST_BUF:   state_next = ST_TRANS;
            ST_TRANS: state_next = ST_FINAL;
            ST_FINAL: state_next = st.dead ? ST_RESOLVE : ST_BEST;
            ST_BEST:  state_next = ST_CHECK;
            ST_RESOLVE: begin
                if (st.can_push) state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (st.can_push) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.acc  = s_tvalid;
            end
            ST_RANGE:   cmd.load    = 1'b1;
            ST_FINAL:   cmd.step    = !st.dead;
            ST_BEST:    cmd.upd     = 1'b1;
            ST_RESOLVE: cmd.resolve = st.can_push;
            ST_FINISH:  cmd.finish  = st.can_push;
            default: ;
        endcase
    end

endmodule

// ===== rtl/mml_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mml_datapath: tables, lookahead buffer and scan registers
// Holds the transition and final tables, the circular lookahead buffer,
// the scan and best-accept registers, one pending result and the output
// register.
// ----------------------------------------------------------------------------
module mml_datapath
    import mml_pkg::*;
#(
    parameter int NUM_STATES = DEF_NUM_STATES,
    parameter int LOOKAHEAD  = DEF_LOOKAHEAD
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mml_cmd_t            cmd,
    output mml_status_t         st,
    // input word
    input  logic [1:0]          in_op,
    input  logic [STATE_W-1:0]  in_sidx,
    input  logic [SYM_W-1:0]    in_lo,
    input  logic [SYM_W-1:0]    in_hi,
    input  logic [STATE_W-1:0]  in_to,
    input  logic                in_ev,
    input  logic [CODE_W-1:0]   in_code,
    input  logic [SYM_W-1:0]    in_byte,
    // configuration
    input  logic                cfg_we,
    input  logic [STATE_W-1:0]  cfg_start,
    output logic [STATE_W-1:0]  start_state,
    // result
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic                m_forced,
    output logic                m_last,
    output logic [CODE_W-1:0]   m_code,
    output logic [OFF_W-1:0]    m_start,
    output logic [OFF_W-1:0]    m_end
);

    localparam int SW    = $clog2(NUM_STATES);
    localparam int XW    = (SW > STATE_W) ? SW : STATE_W;
    localparam int TAW   = SW + SYM_W;
    localparam int TDEP  = NUM_STATES * 256;
    localparam int BW    = $clog2(LOOKAHEAD);
    localparam int FW    = $clog2(LOOKAHEAD + 1);
    localparam int PW    = FW + 1;

    // scan control registers
    logic [BW-1:0]      head_reg, head_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [FW-1:0]      len_reg, len_next;
    logic [STATE_W-1:0] sst_reg, sst_next;
    logic               bv_reg, bv_next;
    logic [FW-1:0]      blen_reg, blen_next;
    logic [CODE_W-1:0]  bcode_reg, bcode_next;
    logic [OFF_W-1:0]   base_reg, base_next;
    logic [STATE_W-1:0] start_reg, start_next;
    logic [TAW-1:0]     clr_reg, clr_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic               pend_v_reg, pend_v_next;
    logic               out_v_reg, out_v_next;

    // registered input fields
    logic [1:0]         op_reg;
    logic [STATE_W-1:0] sidx_reg, to_reg;
    logic [SYM_W-1:0]   hi_reg, lo_reg;
    logic               ev_reg;

    // pending and output payload
    logic               pend_kind, pend_forced;
    logic [CODE_W-1:0]  pend_code;
    logic [OFF_W-1:0]   pend_start, pend_end;
    logic               out_kind, out_forced, out_last;
    logic [CODE_W-1:0]  out_code;
    logic [OFF_W-1:0]   out_start, out_end;

    logic [STATE_W-1:0] st_eff;
    logic [XW-1:0]      st_x, sidx_x, in_sidx_x, q_x;
    logic [PW-1:0]      wsum, rsum, hsum;
    logic [BW-1:0]      wptr, rptr;
    logic [FW-1:0]      cut_n;
    logic               out_free, push, forced;

    logic               buf_we;
    logic [SYM_W-1:0]   buf_rdata;
    logic               tr_we;
    logic [TAW-1:0]     tr_waddr, tr_raddr;
    logic [STATE_W:0]   tr_wdata, tr_rdata;
    logic               fin_we;
    logic [SW-1:0]      fin_waddr, fin_raddr;
    logic [CODE_W:0]    fin_wdata, fin_rdata;

    // state seen by the next table read
    assign st_eff    = (len_reg == '0) ? start_reg : sst_reg;
    assign st_x      = XW'(st_eff);
    assign sidx_x    = XW'(sidx_reg);
    assign in_sidx_x = XW'(in_sidx);
    assign q_x       = XW'(tr_rdata[STATE_W-1:0]);

    // circular buffer pointers
    always_comb begin
        wsum = PW'(head_reg) + PW'(fill_reg);
        if (wsum >= PW'(LOOKAHEAD)) wsum = wsum - PW'(LOOKAHEAD);
        rsum = PW'(head_reg) + PW'(len_reg);
        if (rsum >= PW'(LOOKAHEAD)) rsum = rsum - PW'(LOOKAHEAD);
        hsum = PW'(head_reg) + PW'(cut_n);
        if (hsum >= PW'(LOOKAHEAD)) hsum = hsum - PW'(LOOKAHEAD);
    end
    assign wptr = wsum[BW-1:0];
    assign rptr = rsum[BW-1:0];

    assign cut_n    = bv_reg ? blen_reg : FW'(1);
    assign forced   = (len_reg >= fill_reg) && (fill_reg >= FW'(LOOKAHEAD));
    assign out_free = !out_v_reg || m_ready;
    assign push     = pend_v_reg && (cmd.resolve || cmd.finish);

    // memory ports
    assign buf_we = cmd.acc && (in_op == OP_DATA) && (fill_reg < FW'(LOOKAHEAD));

    assign tr_we    = cmd.clr || cmd.load;
    assign tr_waddr = cmd.clr ? clr_reg : {sidx_x[SW-1:0], sym_reg};
    assign tr_wdata = cmd.clr ? '0 : (ev_reg ? {1'b1, to_reg} : '0);
    assign tr_raddr = {st_x[SW-1:0], buf_rdata};

    assign fin_we    = cmd.clr ? (clr_reg < TAW'(NUM_STATES))
                               : (cmd.acc && (in_op == OP_FINAL)
                                  && (int'(in_sidx) < NUM_STATES));
    assign fin_waddr = cmd.clr ? clr_reg[SW-1:0] : in_sidx_x[SW-1:0];
    assign fin_wdata = cmd.clr ? '0 : (in_ev ? {1'b1, in_code} : '0);
    assign fin_raddr = q_x[SW-1:0];

    mml_ram #(.WIDTH(SYM_W), .DEPTH(LOOKAHEAD)) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (wptr),
        .wdata (in_byte),
        .raddr (rptr),
        .rdata (buf_rdata)
    );

    mml_ram #(.WIDTH(STATE_W + 1), .DEPTH(TDEP)) u_trans (
        .aclk  (aclk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    mml_ram #(.WIDTH(CODE_W + 1), .DEPTH(NUM_STATES)) u_final (
        .aclk  (aclk),
        .we    (fin_we),
        .waddr (fin_waddr),
        .wdata (fin_wdata),
        .raddr (fin_raddr),
        .rdata (fin_rdata)
    );

    // status to the controller
    always_comb begin
        st            = '0;
        st.clear_done = (clr_reg == TAW'(TDEP - 1));
        st.range_done = (sym_reg == hi_reg);
        st.op         = op_reg;
        st.range_req  = (op_reg == OP_LOAD) && (int'(sidx_reg) < NUM_STATES)
                        && (int'(to_reg) < NUM_STATES) && (lo_reg <= hi_reg);
        st.scan_more  = (len_reg < fill_reg);
        st.full       = (fill_reg >= FW'(LOOKAHEAD));
        st.nonempty   = (fill_reg != '0);
        st.dead       = !tr_rdata[STATE_W] || (int'(st_eff) >= NUM_STATES);
        st.can_push   = !pend_v_reg || out_free;
        st.pend_valid = pend_v_reg;
    end

    // control next values
    always_comb begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        sst_next    = sst_reg;
        bv_next     = bv_reg;
        blen_next   = blen_reg;
        bcode_next  = bcode_reg;
        base_next   = base_reg;
        start_next  = cfg_we ? cfg_start : start_reg;
        clr_next    = cmd.clr ? clr_reg + TAW'(1) : clr_reg;
        sym_next    = cmd.acc ? in_lo : (cmd.load ? sym_reg + SYM_W'(1) : sym_reg);
        pend_v_next = pend_v_reg;
        out_v_next  = push ? 1'b1 : (m_ready ? 1'b0 : out_v_reg);

        if (buf_we) fill_next = fill_reg + FW'(1);
        if (cmd.step) begin
            sst_next = tr_rdata[STATE_W-1:0];
            len_next = len_reg + FW'(1);
        end
        if (cmd.upd && fin_rdata[CODE_W]) begin
            bv_next    = 1'b1;
            blen_next  = len_reg;
            bcode_next = fin_rdata[CODE_W-1:0];
        end
        // token cut: drop the lexeme and restart the scan
        if (cmd.resolve) begin
            head_next   = hsum[BW-1:0];
            fill_next   = fill_reg - cut_n;
            base_next   = base_reg + OFF_W'(cut_n);
            len_next    = '0;
            bv_next     = 1'b0;
            pend_v_next = 1'b1;
        end
        if (cmd.finish) begin
            pend_v_next = 1'b0;
            if (op_reg == OP_EOI) base_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            fill_reg   <= '0;
            len_reg    <= '0;
            sst_reg    <= '0;
            bv_reg     <= 1'b0;
            blen_reg   <= '0;
            bcode_reg  <= '0;
            base_reg   <= '0;
            start_reg  <= '0;
            clr_reg    <= '0;
            sym_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            sst_reg    <= sst_next;
            bv_reg     <= bv_next;
            blen_reg   <= blen_next;
            bcode_reg  <= bcode_next;
            base_reg   <= base_next;
            start_reg  <= start_next;
            clr_reg    <= clr_next;
            sym_reg    <= sym_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            op_reg   <= in_op;
            sidx_reg <= in_sidx;
            lo_reg   <= in_lo;
            hi_reg   <= in_hi;
            to_reg   <= in_to;
            ev_reg   <= in_ev;
        end
        if (cmd.resolve) begin
            pend_kind   <= bv_reg ? KIND_TOKEN : KIND_ERROR;
            pend_code   <= bv_reg ? bcode_reg : '0;
            pend_start  <= base_reg;
            pend_end    <= base_reg + OFF_W'(cut_n);
            pend_forced <= forced;
        end
        if (push) begin
            out_kind   <= pend_kind;
            out_code   <= pend_code;
            out_start  <= pend_start;
            out_end    <= pend_end;
            out_forced <= pend_forced;
            out_last   <= cmd.finish;
        end
    end

    assign start_state = start_reg;
    assign m_valid     = out_v_reg;
    assign m_kind      = out_kind;
    assign m_forced    = out_forced;
    assign m_last      = out_last;
    assign m_code      = out_code;
    assign m_start     = out_start;
    assign m_end       = out_end;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for dfa_maximal_munch_lexer
// Loads a small lexer DFA (identifiers, numbers, '=' / '==', quoted strings),
// then streams directed and random text through it. A behavioural tokeniser
// in the bench predicts every result word. Both sides idle at random, and the
// receiver holds off for a long stretch once so that the input stalls.
// ----------------------------------------------------------------------------
module tb
    import mml_pkg::*;
;

    localparam int NSTATES = 64;
    localparam int LOOKAHEAD = 32;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int SETTLE = 400;

    // one input word
    typedef struct {
        logic [1:0]  op;
        logic [5:0]  sidx;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [5:0]  to;
        logic        vld;
        logic [15:0] code;
        logic [7:0]  dbyte;
    } lex_word_t;

    // one result word
    typedef struct {
        logic        kind;
        logic [15:0] code;
        logic [31:0] start_off;
        logic [31:0] end_off;
        logic        forced;
        logic        last;
    } token_t;

    // directed row: typed result only where it is obvious
    typedef struct {
        lex_word_t w;
        bit        typed;
        token_t    tok;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dfa_maximal_munch_lexer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [6:0]  trans_mem [0:NSTATES*256-1];
    logic [16:0] final_mem [0:NSTATES-1];
    logic [7:0]  la_buf [0:LOOKAHEAD-1];
    int          la_fill;
    int          scan_len;
    logic [5:0]  scan_q;
    logic [5:0]  start_q;
    bit          best_ok;
    int          best_len;
    logic [15:0] best_code;
    logic [31:0] tok_base;

    token_t      token_q [$];
    int          mismatches = 0;
    int          words_sent = 0;
    bit          calm = 0;
    bit          long_hold = 0;
    int unsigned cyc = 0;

    // clock
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("[dfa_maximal_munch_lexer] ERROR");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic void restart_scan();
        scan_q = start_q;
        scan_len = 0;
        best_ok = 0;
        best_len = 0;
        best_code = '0;
    endfunction

    // 1 when the scan runs into a missing transition
    function automatic bit scan_ahead();
        logic [6:0] e;
        while (scan_len < la_fill) begin
            e = trans_mem[{scan_q, la_buf[scan_len]}];
            if (!e[6]) return 1;
            scan_q = e[5:0];
            scan_len++;
            if (final_mem[scan_q][16]) begin
                best_ok = 1;
                best_len = scan_len;
                best_code = final_mem[scan_q][15:0];
            end
        end
        return 0;
    endfunction

    function automatic void cut_token(logic forced);
        token_t t;
        int n;
        n = best_ok ? best_len : 1;
        if (n > la_fill) n = la_fill;
        t.kind = best_ok ? KIND_TOKEN : KIND_ERROR;
        t.code = best_ok ? best_code : 16'd0;
        t.start_off = tok_base;
        t.end_off = tok_base + n;
        t.forced = forced;
        t.last = 0;
        token_q.push_back(t);
        for (int i = 0; i + n < la_fill; i++) la_buf[i] = la_buf[i + n];
        la_fill -= n;
        tok_base += n;
        restart_scan();
    endfunction

    function automatic void lexer_predict(lex_word_t w);
        int before_n;
        before_n = token_q.size();
        case (w.op)
            OP_LOAD: begin
                for (int c = w.lo; c <= w.hi; c++)
                    trans_mem[{w.sidx, c[7:0]}] = w.vld ? {1'b1, w.to} : 7'd0;
            end
            OP_FINAL: final_mem[w.sidx] = w.vld ? {1'b1, w.code} : 17'd0;
            OP_DATA: begin
                if (la_fill < LOOKAHEAD) la_buf[la_fill++] = w.dbyte;
                forever begin
                    if (scan_ahead()) cut_token(0);
                    else if (la_fill >= LOOKAHEAD) cut_token(1);
                    else break;
                end
            end
            default: begin
                forever begin
                    if (scan_ahead() || la_fill > 0) cut_token(0);
                    else break;
                end
                tok_base = '0;
                restart_scan();
            end
        endcase
        if (token_q.size() > before_n) token_q[token_q.size() - 1].last = 1;
    endfunction

    // ---------------- word builders ----------------
    function automatic lex_word_t ld(int s, int lo, int hi, int to, bit v);
        lex_word_t w;
        w = '{OP_LOAD, s[5:0], lo[7:0], hi[7:0], to[5:0], v,
              16'($urandom), 8'($urandom)};
        return w;
    endfunction

    function automatic lex_word_t fn(int s, bit v, int code);
        lex_word_t w;
        w = '{OP_FINAL, s[5:0], 8'($urandom), 8'($urandom), 6'($urandom), v,
              code[15:0], 8'($urandom)};
        return w;
    endfunction

    function automatic lex_word_t dt(int b);
        lex_word_t w;
        w = '{OP_DATA, 6'($urandom), 8'($urandom), 8'($urandom), 6'($urandom),
              1'($urandom), 16'($urandom), b[7:0]};
        return w;
    endfunction

    function automatic lex_word_t eoi();
        lex_word_t w;
        w = '{OP_EOI, 6'($urandom), 8'($urandom), 8'($urandom), 6'($urandom),
              1'($urandom), 16'($urandom), 8'($urandom)};
        return w;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_word(lex_word_t w, bit typed = 0, token_t tok = '{default: 0});
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge aclk);
            s_tvalid <= 0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tuser <= w.op;
        s_tdata <= {3'b0, w.dbyte, w.code, w.vld, w.to, w.hi, w.lo, w.sidx};
        do @(posedge aclk); while (!s_tready);
        if (typed) begin
            // keep the predictor in step, but check against the typed word
            lexer_predict(w);
            void'(token_q.pop_back());
            token_q.push_back(tok);
        end else begin
            lexer_predict(w);
        end
        words_sent++;
    endtask

    task automatic set_start(int st);
        @(negedge aclk);
        s_tvalid <= 0;
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {REG_START_STATE, 2'b00};
        pwdata <= {26'($urandom_range(0, 32'h03FF_FFFF)), st[5:0]};
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        start_q = st[5:0];
        if (scan_len == 0) scan_q = start_q;
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // wait for the block to go quiet
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 0;
        while (token_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // one random lexeme or a piece of noise
    task automatic send_lexeme();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            len = $urandom_range(1, 6);
            repeat (len) send_word(dt($urandom_range("a", "z")));
        end else if (pick < 45) begin
            len = $urandom_range(1, 5);
            repeat (len) send_word(dt($urandom_range("0", "9")));
        end else if (pick < 53) begin
            send_word(dt("="));
            if ($urandom_range(0, 1)) send_word(dt("="));
        end else if (pick < 63) begin
            // quoted string, sometimes unclosed or longer than the lookahead
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
            send_word(dt("\""));
            repeat (len) send_word(dt($urandom_range("a", "z")));
            if ($urandom_range(0, 4) != 0) send_word(dt("\""));
        end else if (pick < 75) begin
            send_word(dt(" "));
        end else if (pick < 88) begin
            send_word(dt($urandom_range(0, 255)));
        end else if (pick < 93) begin
            send_word(eoi());
        end else if (pick < 97) begin
            send_word(ld($urandom_range(8, 63), $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 63), $urandom_range(0, 1)));
        end else begin
            send_word(fn($urandom_range(8, 63), $urandom_range(0, 1), $urandom_range(0, 65535)));
        end
    endtask

    // ---------------- receiver ----------------
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 0;
                repeat (600) @(negedge aclk);
                long_hold = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    // result check
    always @(posedge aclk) begin
        token_t exp_t;
        token_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser[0], m_tdata[15:0], m_tdata[47:16], m_tdata[79:48],
                    m_tuser[1], m_tlast};
            if (token_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %p", got);
            end else begin
                exp_t = token_q.pop_front();
                if (got !== exp_t) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", exp_t, got);
                end
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        dir_row_t dir_tab [$];
        token_t t;

        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < NSTATES * 256; i++) trans_mem[i] = '0;
        for (int i = 0; i < NSTATES; i++) final_mem[i] = '0;
        la_fill = 0;
        tok_base = '0;
        start_q = '0;
        restart_scan();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        set_start(0);

        // directed part
        t = '{KIND_ERROR, 16'd0, 32'd0, 32'd1, 1'b0, 1'b1};
        dir_tab.push_back('{dt("x"), 1, t});          // empty tables: every byte is an error
        t = '{KIND_ERROR, 16'd0, 32'd1, 32'd2, 1'b0, 1'b1};
        dir_tab.push_back('{dt(8'hFF), 1, t});
        dir_tab.push_back('{eoi(), 0, t});            // empty buffer: nothing
        dir_tab.push_back('{ld(0, "a", "z", 1, 1), 0, t});
        dir_tab.push_back('{ld(1, "a", "z", 1, 1), 0, t});
        dir_tab.push_back('{fn(1, 1, 16'hFFFF), 0, t});
        dir_tab.push_back('{ld(7, 0, 255, 63, 1), 0, t});   // whole byte range
        dir_tab.push_back('{ld(7, 0, 255, 0, 0), 0, t});    // and cleared again
        dir_tab.push_back('{ld(2, 200, 100, 5, 1), 0, t});  // empty range writes nothing
        dir_tab.push_back('{fn(63, 1, 0), 0, t});
        dir_tab.push_back('{fn(63, 0, 0), 0, t});
        dir_tab.push_back('{dt("a"), 0, t});
        dir_tab.push_back('{dt("b"), 0, t});
        t = '{KIND_TOKEN, 16'hFFFF, 32'd0, 32'd2, 1'b0, 1'b1};
        dir_tab.push_back('{eoi(), 1, t});
        // start state marked final: only counts after one byte
        dir_tab.push_back('{fn(0, 1, 16'h1234), 0, t});
        dir_tab.push_back('{ld(0, "!", "!", 0, 1), 0, t});
        dir_tab.push_back('{dt("!"), 0, t});
        dir_tab.push_back('{dt("!"), 0, t});
        dir_tab.push_back('{dt("?"), 0, t});
        dir_tab.push_back('{fn(0, 0, 0), 0, t});
        // table write in the middle of a scan
        dir_tab.push_back('{dt("q"), 0, t});
        dir_tab.push_back('{ld(1, "q", "q", 1, 0), 0, t});
        dir_tab.push_back('{dt("q"), 0, t});
        dir_tab.push_back('{eoi(), 0, t});
        foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].tok);

        // lexer tables: identifiers 1, numbers 2, '=' 3, '==' 4, strings 7
        send_word(ld(1, "a", "z", 1, 1));
        send_word(ld(0, "0", "9", 2, 1));
        send_word(ld(2, "0", "9", 2, 1));
        send_word(fn(2, 1, 2));
        send_word(fn(1, 1, 1));
        send_word(ld(0, "=", "=", 3, 1));
        send_word(ld(3, "=", "=", 4, 1));
        send_word(fn(3, 1, 3));
        send_word(fn(4, 1, 4));
        send_word(ld(0, "\"", "\"", 5, 1));
        send_word(ld(5, 0, 255, 5, 1));
        send_word(ld(5, "\"", "\"", 6, 1));
        send_word(fn(6, 1, 7));

        // random text, with one long receiver hold-off
        while (words_sent < 260) begin
            if (words_sent > 120 && words_sent < 130) long_hold = 1;
            send_lexeme();
        end
        send_word(eoi());
        drain();

        // start state with no transitions: all errors
        set_start(63);
        while (words_sent < 300) send_lexeme();
        send_word(eoi());
        drain();

        // scans begin inside a string
        set_start(5);
        while (words_sent < 340) send_lexeme();
        drain();

        // back to normal, no idling to the end
        set_start(0);
        calm = 1;
        while (words_sent < 410) send_lexeme();
        send_word(eoi());
        drain();

        if (mismatches == 0 && token_q.size() == 0) begin
            $display("[dfa_maximal_munch_lexer] OK");
        end else begin
            $display("[dfa_maximal_munch_lexer] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mml_pkg.sv
rtl/mml_ram.sv
rtl/mml_ctrl.sv
rtl/mml_datapath.sv
rtl/dfa_maximal_munch_lexer.sv
tb/tb.sv
